// File: rtl/core/crop_scale_flip_pixel_remap_macros.svh
// Assertion macros shared by the pixel remapper RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef CROP_SCALE_FLIP_PIXEL_REMAP_MACROS_SVH
`define CROP_SCALE_FLIP_PIXEL_REMAP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CSFPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CSFPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/csfpr_pkg.sv
// Types, constants and helper functions of the pixel remapper.
// Used by the divider pipeline and the top level; no dependencies.
package csfpr_pkg;

  localparam int unsigned DIM_W   = 12;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned SADDR_W = 16;
  localparam int unsigned QUOT_W  = 2 * DIM_W;
  localparam int unsigned REM_W   = DIM_W;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register reset values.
  localparam logic [DIM_W-1:0] RST_OUT_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_OUT_HEIGHT = 12'd480;
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 12'd480;
  localparam logic             RST_MIRROR_ON  = 1'b0;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    REG_OUT_WIDTH  = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_SRC_WIDTH  = 3'd2,
    REG_SRC_HEIGHT = 3'd3,
    REG_MIRROR_ON  = 3'd4
  } reg_e;

  // Per-beat side information that travels down the pipeline.
  typedef struct packed {
    req_e               kind;
    logic               bad;
    logic [SADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]   wr_data;
  } tag_t;

  // One lane of the restoring divider: partial remainder and the
  // dividend bits still to go, with quotient bits shifting in at the bottom.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] nq;
  } lane_t;

  // One restoring division step: bring in the next dividend bit and
  // subtract the divisor when it fits.
  function automatic lane_t div_step(lane_t l, logic [DIM_W-1:0] den);
    logic [REM_W:0] t;
    logic           ge;
    lane_t          r;
    t     = {l.rem, l.nq[QUOT_W-1]};
    ge    = (t >= {1'b0, den});
    r.rem = ge ? REM_W'(t - {1'b0, den}) : t[REM_W-1:0];
    r.nq  = {l.nq[QUOT_W-2:0], ge};
    return r;
  endfunction

  // Swap bytes 0 and 2 so that B,G,R,A becomes R,G,B,A.
  function automatic logic [PIX_W-1:0] swap_rb(logic [PIX_W-1:0] p);
    return {p[31:24], p[7:0], p[15:8], p[23:16]};
  endfunction

endpackage

// File: rtl/core/csfpr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies; contents are not reset.
module csfpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/csfpr_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage.
// Depends on csfpr_pkg for widths, tag_t, lane_t and div_step.
module csfpr_div import csfpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  tag_t              tag_i,
  input  logic [DIM_W-1:0]  den_i,
  input  logic [QUOT_W-1:0] num_row_i,
  input  logic [QUOT_W-1:0] num_col_i,
  output logic              valid_o,
  output tag_t              tag_o,
  output logic [QUOT_W-1:0] quo_row_o,
  output logic [QUOT_W-1:0] quo_col_o
);

  logic             valid_q [QUOT_W];
  tag_t             tag_q   [QUOT_W];
  lane_t            row_q   [QUOT_W];
  lane_t            col_q   [QUOT_W];
  logic [DIM_W-1:0] den_q   [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic             valid_in;
    tag_t             tag_in;
    lane_t            row_in;
    lane_t            col_in;
    logic [DIM_W-1:0] den_in;

    // Stage input: the dividend enters with a cleared remainder.
    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign tag_in   = tag_i;
      assign row_in   = '{rem: '0, nq: num_row_i};
      assign col_in   = '{rem: '0, nq: num_col_i};
      assign den_in   = den_i;
    end else begin : g_rest
      assign valid_in = valid_q[k-1];
      assign tag_in   = tag_q[k-1];
      assign row_in   = row_q[k-1];
      assign col_in   = col_q[k-1];
      assign den_in   = den_q[k-1];
    end

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= valid_in;
      end
    end

    // Stage payload: one division step on each lane.
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        tag_q[k] <= tag_in;
        row_q[k] <= div_step(row_in, den_in);
        col_q[k] <= div_step(col_in, den_in);
        den_q[k] <= den_in;
      end
    end
  end

  assign valid_o   = valid_q[QUOT_W-1];
  assign tag_o     = tag_q[QUOT_W-1];
  assign quo_row_o = row_q[QUOT_W-1].nq;
  assign quo_col_o = col_q[QUOT_W-1].nq;

endmodule

// File: rtl/core/crop_scale_flip_pixel_remap.sv
// Nearest-neighbor crop, scale and flip remapper over a source frame RAM.
// A read result passes through 3 setup stages, a 24-stage divider, 2 address stages,
// the frame RAM read and the output register. Throughput: one beat per cycle while
// in_stall_o is low; the frame RAM takes one write or one read per cycle.
// Reset returns the configuration registers to their defaults and clears all pipeline
// valid bits; the frame RAM is not cleared and holds undefined data until written.
`include "crop_scale_flip_pixel_remap_macros.svh"

module crop_scale_flip_pixel_remap import csfpr_pkg::*; #(
  parameter int unsigned SRC_PIXELS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [SADDR_W-1:0] src_addr_i,
  input  logic [PIX_W-1:0]   pixel_in_i,
  input  logic [DIM_W-1:0]   out_x_i,
  input  logic [DIM_W-1:0]   out_y_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   pixel_out_o,
  output logic               out_of_range_o
);

  localparam int unsigned ADDR_W = $clog2(SRC_PIXELS);
  localparam int unsigned PROD_W = QUOT_W + DIM_W;
  localparam int unsigned MAP_W  = PROD_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] out_width_q, out_height_q, src_width_q, src_height_q;
  logic             mirror_on_q;
  logic             cfg_wr;
  reg_e             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[PADDR_W-1:2]);

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= RST_OUT_WIDTH;
      out_height_q <= RST_OUT_HEIGHT;
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      mirror_on_q  <= RST_MIRROR_ON;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OUT_WIDTH:  out_width_q  <= pwdata[DIM_W-1:0];
        REG_OUT_HEIGHT: out_height_q <= pwdata[DIM_W-1:0];
        REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_W-1:0];
        REG_MIRROR_ON:  mirror_on_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    unique case (cfg_sel)
      REG_OUT_WIDTH:  prdata = PDATA_W'(out_width_q);
      REG_OUT_HEIGHT: prdata = PDATA_W'(out_height_q);
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
      REG_MIRROR_ON:  prdata = PDATA_W'(mirror_on_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline moves unless the output skid is occupied.
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_valid_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate flip, range check and the ratio cross products
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  tag_t              s1_tag_q, s1_tag_d;
  logic [DIM_W-1:0]  s1_sx_q, s1_sx_d, s1_sy_q, s1_sy_d;
  logic [QUOT_W-1:0] s1_pa_q, s1_pa_d, s1_pb_q, s1_pb_d;
  logic              zero_dim;

  assign zero_dim = (out_width_q == '0) || (out_height_q == '0) ||
                    (src_width_q == '0) || (src_height_q == '0);

  always_comb begin
    s1_tag_d.kind    = req_e'(req_type_i);
    s1_tag_d.bad     = zero_dim || (out_x_i >= out_width_q) || (out_y_i >= out_height_q);
    s1_tag_d.wr_addr = src_addr_i;
    s1_tag_d.wr_data = pixel_in_i;
    s1_sy_d          = out_height_q - DIM_W'(1) - out_y_i;
    s1_sx_d          = mirror_on_q ? (out_width_q - DIM_W'(1) - out_x_i) : out_x_i;
    s1_pa_d          = src_width_q * out_height_q;
    s1_pb_d          = src_height_q * out_width_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick one scale ratio for both axes
  // ---------------------------------------------------------------------------
  logic             s2_valid_q;
  tag_t             s2_tag_q;
  logic [DIM_W-1:0] s2_sx_q, s2_sy_q, s2_num_q, s2_num_d, s2_den_q, s2_den_d;

  always_comb begin
    if (s1_pa_q > s1_pb_q) begin
      s2_num_d = src_height_q;
      s2_den_d = out_height_q;
    end else begin
      s2_num_d = src_width_q;
      s2_den_d = out_width_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale both coordinates by the numerator
  // ---------------------------------------------------------------------------
  logic              s3_valid_q;
  tag_t              s3_tag_q;
  logic [DIM_W-1:0]  s3_den_q;
  logic [QUOT_W-1:0] s3_row_q, s3_row_d, s3_col_q, s3_col_d;

  assign s3_row_d = s2_sy_q * s2_num_q;
  assign s3_col_d = s2_sx_q * s2_num_q;

  // Pipeline registers of stages 1 to 3.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q <= s1_tag_d;
      s1_sx_q  <= s1_sx_d;
      s1_sy_q  <= s1_sy_d;
      s1_pa_q  <= s1_pa_d;
      s1_pb_q  <= s1_pb_d;
      s2_tag_q <= s1_tag_q;
      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_num_q <= s2_num_d;
      s2_den_q <= s2_den_d;
      s3_tag_q <= s2_tag_q;
      s3_den_q <= s2_den_q;
      s3_row_q <= s3_row_d;
      s3_col_q <= s3_col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Truncating division of both coordinates by the denominator
  // ---------------------------------------------------------------------------
  logic              dv_valid;
  tag_t              dv_tag;
  logic [QUOT_W-1:0] dv_row, dv_col;

  csfpr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (s3_valid_q),
    .tag_i     (s3_tag_q),
    .den_i     (s3_den_q),
    .num_row_i (s3_row_q),
    .num_col_i (s3_col_q),
    .valid_o   (dv_valid),
    .tag_o     (dv_tag),
    .quo_row_o (dv_row),
    .quo_col_o (dv_col)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: row times stride
  // ---------------------------------------------------------------------------
  logic              s4_valid_q;
  tag_t              s4_tag_q;
  logic [PROD_W-1:0] s4_prod_q, s4_prod_d;
  logic [QUOT_W-1:0] s4_col_q;

  assign s4_prod_d = dv_row * src_width_q;

  // ---------------------------------------------------------------------------
  // Stage 5: final address, store bound check and RAM command
  // ---------------------------------------------------------------------------
  logic              r_valid_q;
  tag_t              r_tag_q;
  logic              r_hit_q, r_hit_d;
  logic [ADDR_W-1:0] r_addr_q, r_addr_d;
  logic [MAP_W-1:0]  map_addr;
  logic              map_oor;
  logic              wr_in_store;

  assign map_addr    = MAP_W'(s4_prod_q) + MAP_W'(s4_col_q);
  assign map_oor     = s4_tag_q.bad || (map_addr >= MAP_W'(SRC_PIXELS));
  assign wr_in_store = MAP_W'(s4_tag_q.wr_addr) < MAP_W'(SRC_PIXELS);

  always_comb begin
    if (s4_tag_q.kind == REQ_READ) begin
      r_hit_d  = !map_oor;
      r_addr_d = map_addr[ADDR_W-1:0];
    end else begin
      r_hit_d  = wr_in_store;
      r_addr_d = ADDR_W'(s4_tag_q.wr_addr);
    end
  end

  // Pipeline registers of stages 4 and 5.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      r_valid_q  <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= dv_valid;
      r_valid_q  <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_tag_q  <= dv_tag;
      s4_prod_q <= s4_prod_d;
      s4_col_q  <= dv_col;
      r_tag_q   <= s4_tag_q;
      r_hit_q   <= r_hit_d;
      r_addr_q  <= r_addr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Source frame RAM. Writes and reads reach it in request order, so a read
  // always sees every earlier write.
  // ---------------------------------------------------------------------------
  logic             ram_we, ram_re;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = adv && r_valid_q && (r_tag_q.kind == REQ_WRITE) && r_hit_q;
  assign ram_re = adv && r_valid_q && (r_tag_q.kind == REQ_READ) && r_hit_q;

  csfpr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SRC_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (r_addr_q),
    .wdata_i (r_tag_q.wr_data),
    .re_i    (ram_re),
    .raddr_i (r_addr_q),
    .rdata_o (ram_rdata)
  );

  // Stage 6: read beats wait here for the RAM data; writes end at the RAM.
  logic m_valid_q;
  logic m_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= r_valid_q && (r_tag_q.kind == REQ_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_oor_q <= !r_hit_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a one-entry skid
  // ---------------------------------------------------------------------------
  logic             inc_valid, inc_oor;
  logic [PIX_W-1:0] inc_pix;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;
  logic             out_oor_q, out_oor_d;
  logic             skid_valid_d;
  logic [PIX_W-1:0] skid_pix_q, skid_pix_d;
  logic             skid_oor_q, skid_oor_d;
  logic             take;

  assign inc_valid = adv && m_valid_q;
  assign inc_oor   = m_oor_q;
  assign inc_pix   = m_oor_q ? '0 : swap_rb(ram_rdata);
  assign take      = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_pix_d    = out_pix_q;
    out_oor_d    = out_oor_q;
    skid_valid_d = skid_valid_q;
    skid_pix_d   = skid_pix_q;
    skid_oor_d   = skid_oor_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pix_d    = skid_pix_q;
        out_oor_d    = skid_oor_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = inc_valid;
        out_pix_d   = inc_pix;
        out_oor_d   = inc_oor;
      end
    end else if (inc_valid) begin
      skid_valid_d = 1'b1;
      skid_pix_d   = inc_pix;
      skid_oor_d   = inc_oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    out_oor_q  <= out_oor_d;
    skid_pix_q <= skid_pix_d;
    skid_oor_q <= skid_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign out_of_range_o = out_oor_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSFPR_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
  `CSFPR_ASSERT_NOW(a_skid_fill, $rose(skid_valid_q), $past(out_valid_q && out_stall_i), "bad fill")
  `CSFPR_ASSERT_NOW(a_skid_drain, $fell(skid_valid_q), $past(take), "skid drained without a take")
  `CSFPR_ASSERT_NOW(a_oor_zero, out_valid_q && out_oor_q, out_pix_q == '0, "flagged pixel not zero")
  `CSFPR_ASSERT_NEXT(a_mem_hold, m_valid_q && in_stall_o, m_valid_q, "read beat lost in a hold")

endmodule
